[rtl/pfc_pkg.sv]
package pfc_pkg;

    localparam int MAX_PAYLOAD = 128;
    localparam int POS_SAT     = MAX_PAYLOAD + 12;
    localparam int POS_W       = $clog2(POS_SAT + 1);
    localparam int LEN_W       = 16;
    localparam int CMP_W       = LEN_W + 1;

    localparam logic [POS_W-1:0] POS_ID_END  = POS_W'(8);
    localparam logic [POS_W-1:0] POS_HDR_END = POS_W'(10);
    localparam logic [POS_W-1:0] POS_MIN     = POS_W'(12);
    localparam logic [POS_W-1:0] POS_LIMIT   = POS_W'(POS_SAT);

    localparam logic [LEN_W-1:0] LEN_MAX     = LEN_W'(MAX_PAYLOAD);
    localparam logic [CMP_W-1:0] HDR_BYTES   = CMP_W'(10);
    localparam logic [CMP_W-1:0] FRAME_MIN   = CMP_W'(12);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);
    localparam logic [CNT_W-1:0] FIFO_ROOM = CNT_W'(FIFO_DEPTH - 2);
    localparam logic [CNT_W-1:0] FIFO_FULL = CNT_W'(FIFO_DEPTH);

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_STATUS  = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDER     = 3'd1;
    localparam logic [2:0] ST_TOO_BIG   = 3'd2;
    localparam logic [2:0] ST_SHORT     = 3'd3;
    localparam logic [2:0] ST_CHECK_BAD = 3'd4;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        logic [7:0]  dst_station;
        logic [7:0]  src_station;
        logic [15:0] packet_type;
        logic [31:0] packet_ident;
        logic [15:0] payload_length;
        logic [15:0] received_checksum;
        logic [2:0]  status;
    } t_item;

    function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

[rtl/packet_frame_checker_top.sv]
// Channel   Direction  Handshake           Payload
// input     in         i_valid / o_ready   i_data_byte, i_final_byte
// result    out        o_valid / i_ready   o_item_kind .. o_status
//
// One byte accepted per cycle while o_ready is high; each byte passes through one register stage.
// A final byte that is also a payload byte yields two transactions, drained one
// per cycle while i_ready is high from a 4-entry output queue; o_ready is high while it holds <= 2.
// Synchronous active-low reset clears the byte counter, sums and queue pointers.
// Output stalls back up through the queue only; no clearing pass after reset.
module packet_frame_checker_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_final_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_item_kind,
    output logic [7:0]  o_payload_byte,
    output logic [7:0]  o_dst_station,
    output logic [7:0]  o_src_station,
    output logic [15:0] o_packet_type,
    output logic [31:0] o_packet_ident,
    output logic [15:0] o_payload_length,
    output logic [15:0] o_received_checksum,
    output logic [2:0]  o_status
);

    logic [pfc_pkg::POS_W-1:0] r_pos, n_pos;
    logic [63:0]               r_hdr, n_hdr;
    logic [15:0]               r_len, n_len;
    logic [15:0]               r_sum, n_sum;
    logic [7:0]                r_pending, n_pending;
    logic [15:0]               r_chk, n_chk;

    pfc_pkg::t_item            r_fifo [pfc_pkg::FIFO_DEPTH];
    logic [pfc_pkg::FIFO_AW-1:0] r_wr, r_rd;
    logic [pfc_pkg::CNT_W-1:0] r_count, n_count;

    logic                      w_accept, w_pop, w_pay, w_sum_byte, w_len_ok;
    logic [pfc_pkg::CMP_W-1:0] w_pos_x, w_cnt_x, w_pay_end, w_len_x;
    logic [15:0]               w_fsum;
    logic [2:0]                w_status;
    logic [15:0]               w_chk_out;
    logic [1:0]                w_push;
    pfc_pkg::t_item            w_pay_item, w_stat_item, w_e0;

    assign w_accept = i_valid & o_ready;
    assign w_pop    = o_valid & i_ready;
    assign w_len_ok = r_len <= pfc_pkg::LEN_MAX;
    assign w_pos_x  = pfc_pkg::CMP_W'(r_pos);
    assign w_pay_end = pfc_pkg::HDR_BYTES + {1'b0, r_len};

    always_comb begin
        n_pos      = r_pos;
        n_hdr      = r_hdr;
        n_len      = r_len;
        n_sum      = r_sum;
        n_pending  = r_pending;
        n_chk      = r_chk;
        w_sum_byte = 1'b0;
        w_pay      = 1'b0;
        if (r_pos < pfc_pkg::POS_ID_END) begin
            n_hdr      = {r_hdr[55:0], i_data_byte};
            w_sum_byte = 1'b1;
        end else if (r_pos < pfc_pkg::POS_HDR_END) begin
            n_len      = {r_len[7:0], i_data_byte};
            w_sum_byte = 1'b1;
        end else if (w_len_ok) begin
            if (w_pos_x < w_pay_end) begin
                w_sum_byte = 1'b1;
                w_pay      = 1'b1;
            end else if (w_pos_x < w_pay_end + pfc_pkg::CMP_W'(2)) begin
                n_chk = {r_chk[7:0], i_data_byte};
            end
        end
        if (w_sum_byte) begin
            if (!r_pos[0]) begin
                n_pending = i_data_byte;
            end else begin
                n_sum = pfc_pkg::oc_add(r_sum, {r_pending, i_data_byte});
            end
        end
        if (r_pos < pfc_pkg::POS_LIMIT) begin
            n_pos = r_pos + pfc_pkg::POS_W'(1);
        end
    end

    // checksum branch implies the current byte is past the payload
    assign w_cnt_x = pfc_pkg::CMP_W'(n_pos);
    assign w_len_x = pfc_pkg::FRAME_MIN + {1'b0, n_len};

    always_comb begin
        w_chk_out = 16'd0;
        w_fsum    = r_len[0] ? pfc_pkg::oc_add(r_sum, {r_pending, 8'd0}) : r_sum;
        if (n_pos < pfc_pkg::POS_MIN) begin
            w_status = pfc_pkg::ST_UNDER;
        end else if (n_len > pfc_pkg::LEN_MAX) begin
            w_status = pfc_pkg::ST_TOO_BIG;
        end else if (w_cnt_x < w_len_x) begin
            w_status = pfc_pkg::ST_SHORT;
        end else begin
            w_status  = ((~w_fsum) == n_chk) ? pfc_pkg::ST_OK : pfc_pkg::ST_CHECK_BAD;
            w_chk_out = n_chk;
        end
    end

    always_comb begin
        w_pay_item              = '0;
        w_pay_item.kind         = pfc_pkg::KIND_PAYLOAD;
        w_pay_item.payload_byte = i_data_byte;

        w_stat_item                   = '0;
        w_stat_item.kind              = pfc_pkg::KIND_STATUS;
        w_stat_item.dst_station       = n_hdr[63:56];
        w_stat_item.src_station       = n_hdr[55:48];
        w_stat_item.packet_type       = n_hdr[47:32];
        w_stat_item.packet_ident      = n_hdr[31:0];
        w_stat_item.payload_length    = n_len;
        w_stat_item.received_checksum = w_chk_out;
        w_stat_item.status            = w_status;

        w_e0   = w_pay ? w_pay_item : w_stat_item;
        w_push = w_accept ? ({1'b0, w_pay} + {1'b0, i_final_byte}) : 2'd0;
        n_count = r_count + pfc_pkg::CNT_W'(w_push) - pfc_pkg::CNT_W'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_hdr     <= '0;
            r_len     <= '0;
            r_sum     <= '0;
            r_pending <= '0;
            r_chk     <= '0;
        end else if (w_accept) begin
            if (i_final_byte) begin
                r_pos     <= '0;
                r_hdr     <= '0;
                r_len     <= '0;
                r_sum     <= '0;
                r_pending <= '0;
                r_chk     <= '0;
            end else begin
                r_pos     <= n_pos;
                r_hdr     <= n_hdr;
                r_len     <= n_len;
                r_sum     <= n_sum;
                r_pending <= n_pending;
                r_chk     <= n_chk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + pfc_pkg::FIFO_AW'(w_push);
            r_rd    <= r_rd + pfc_pkg::FIFO_AW'(w_pop);
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push != 2'd0) begin
            r_fifo[r_wr] <= w_e0;
        end
        if (w_push == 2'd2) begin
            r_fifo[r_wr + pfc_pkg::FIFO_AW'(1)] <= w_stat_item;
        end
    end

    assign o_ready             = r_count <= pfc_pkg::FIFO_ROOM;
    assign o_valid             = r_count != '0;
    assign o_item_kind         = r_fifo[r_rd].kind;
    assign o_payload_byte      = r_fifo[r_rd].payload_byte;
    assign o_dst_station       = r_fifo[r_rd].dst_station;
    assign o_src_station       = r_fifo[r_rd].src_station;
    assign o_packet_type       = r_fifo[r_rd].packet_type;
    assign o_packet_ident      = r_fifo[r_rd].packet_ident;
    assign o_payload_length    = r_fifo[r_rd].payload_length;
    assign o_received_checksum = r_fifo[r_rd].received_checksum;
    assign o_status            = r_fifo[r_rd].status;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= pfc_pkg::FIFO_FULL)
        else $error("output queue overflow");

    a_pos_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= pfc_pkg::POS_LIMIT)
        else $error("byte position past saturation");

    a_final_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_final_byte) |=> (r_count != '0))
        else $error("status transaction not queued");

    a_pay_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind == pfc_pkg::KIND_PAYLOAD) |->
        (o_status == pfc_pkg::ST_OK && o_payload_length == 16'd0 &&
         o_received_checksum == 16'd0 && o_packet_ident == 32'd0))
        else $error("payload transaction carries header fields");

    a_stat_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item_kind == pfc_pkg::KIND_STATUS) |->
        (o_payload_byte == 8'd0 && o_status <= pfc_pkg::ST_CHECK_BAD))
        else $error("malformed status transaction");

endmodule

[sim/packet_frame_checker_top_tb.sv]
module packet_frame_checker_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_ITEMS  = 1250;
    localparam int IDLE_LIMIT = 2000;
    localparam int DRAIN_WAIT = 20;
    localparam int HDR_LEN    = 10;
    localparam int OVERHEAD   = 12;

    typedef struct {
        logic [7:0]     data;
        logic           fin;
        bit             typed;
        pfc_pkg::t_item want;
    } t_script_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_final_byte;
    logic        o_valid;
    logic        i_ready;
    logic        o_item_kind;
    logic [7:0]  o_payload_byte;
    logic [7:0]  o_dst_station;
    logic [7:0]  o_src_station;
    logic [15:0] o_packet_type;
    logic [31:0] o_packet_ident;
    logic [15:0] o_payload_length;
    logic [15:0] o_received_checksum;
    logic [2:0]  o_status;

    pfc_pkg::t_item awaited_items[$];
    t_script_row    script[$];
    int             n_fail      = 0;
    int             idle_cycles = 0;
    int             live_bytes  = 0;

    int unsigned rx_count;
    logic [63:0] hdr_bytes;
    logic [15:0] len_word;
    logic [15:0] word_sum;
    logic [7:0]  high_half;
    logic [15:0] chk_word;

    packet_frame_checker_top u_top (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_data_byte         (i_data_byte),
        .i_final_byte        (i_final_byte),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_item_kind         (o_item_kind),
        .o_payload_byte      (o_payload_byte),
        .o_dst_station       (o_dst_station),
        .o_src_station       (o_src_station),
        .o_packet_type       (o_packet_type),
        .o_packet_ident      (o_packet_ident),
        .o_payload_length    (o_payload_length),
        .o_received_checksum (o_received_checksum),
        .o_status            (o_status)
    );

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    // end-around carry add
    function automatic logic [15:0] wrap_add(input logic [15:0] a, input logic [15:0] b);
        int unsigned total;
        total = a + b;
        if (total > 32'hFFFF) total -= 32'hFFFF;
        return 16'(total);
    endfunction

    function automatic void clear_frame();
        rx_count  = 0;
        hdr_bytes = '0;
        len_word  = '0;
        word_sum  = '0;
        high_half = '0;
        chk_word  = '0;
    endfunction

    function automatic void add_sum_byte(input int unsigned pos, input logic [7:0] b);
        if (pos[0] == 1'b0) high_half = b;
        else word_sum = wrap_add(word_sum, {high_half, b});
    endfunction

    // Returns 1 when the byte is not simply discarded.
    function automatic bit absorb_byte(input logic [7:0] b, input logic fin);
        int unsigned    pos;
        int unsigned    plen;
        bit             used;
        pfc_pkg::t_item res;
        logic [15:0]    fold;
        pos  = rx_count;
        plen = len_word;
        used = 1'b1;
        if (pos < 8) begin
            hdr_bytes = {hdr_bytes[55:0], b};
            add_sum_byte(pos, b);
        end else if (pos < HDR_LEN) begin
            len_word = {len_word[7:0], b};
            add_sum_byte(pos, b);
        end else if (plen > pfc_pkg::MAX_PAYLOAD) begin
            used = 1'b0;
        end else if (pos < HDR_LEN + plen) begin
            add_sum_byte(pos, b);
            res              = '0;
            res.kind         = pfc_pkg::KIND_PAYLOAD;
            res.payload_byte = b;
            awaited_items.push_back(res);
        end else if (pos < OVERHEAD + plen) begin
            chk_word = {chk_word[7:0], b};
        end else begin
            used = 1'b0;
        end
        if (rx_count < pfc_pkg::MAX_PAYLOAD + OVERHEAD) rx_count++;
        if (fin) begin
            plen               = len_word;
            res                = '0;
            res.kind           = pfc_pkg::KIND_STATUS;
            res.dst_station    = hdr_bytes[63:56];
            res.src_station    = hdr_bytes[55:48];
            res.packet_type    = hdr_bytes[47:32];
            res.packet_ident   = hdr_bytes[31:0];
            res.payload_length = len_word;
            if (rx_count < OVERHEAD) begin
                res.status = pfc_pkg::ST_UNDER;
            end else if (plen > pfc_pkg::MAX_PAYLOAD) begin
                res.status = pfc_pkg::ST_TOO_BIG;
            end else if (rx_count < OVERHEAD + plen) begin
                res.status = pfc_pkg::ST_SHORT;
            end else begin
                fold = word_sum;
                if (plen % 2 == 1) fold = wrap_add(fold, {high_half, 8'h00});
                res.status            = (16'(~fold) == chk_word) ?
                                        pfc_pkg::ST_OK : pfc_pkg::ST_CHECK_BAD;
                res.received_checksum = chk_word;
            end
            awaited_items.push_back(res);
            clear_frame();
        end
        return used | fin;
    endfunction

    function automatic logic [15:0] frame_sum(input logic [7:0] fb[$]);
        logic [15:0] acc;
        acc = '0;
        for (int i = 0; i < fb.size(); i += 2)
            acc = wrap_add(acc, {fb[i], (i + 1 < fb.size()) ? fb[i + 1] : 8'h00});
        return acc;
    endfunction

    function automatic pfc_pkg::t_item closing(input logic [7:0] dest, input logic [7:0] src,
                                               input logic [15:0] ptype,
                                               input logic [31:0] ident,
                                               input logic [15:0] plen,
                                               input logic [15:0] chk,
                                               input logic [2:0] st);
        pfc_pkg::t_item res;
        res                   = '0;
        res.kind              = pfc_pkg::KIND_STATUS;
        res.dst_station       = dest;
        res.src_station       = src;
        res.packet_type       = ptype;
        res.packet_ident      = ident;
        res.payload_length    = plen;
        res.received_checksum = chk;
        res.status            = st;
        return res;
    endfunction

    function automatic void row(input logic [7:0] data, input logic fin = 1'b0,
                                input bit typed = 1'b0, input pfc_pkg::t_item want = '0);
        t_script_row r;
        r.data  = data;
        r.fin   = fin;
        r.typed = typed;
        r.want  = want;
        script.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic fin, input int gap,
                             input bit typed, input pfc_pkg::t_item want);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_data_byte  <= b;
        i_final_byte <= fin;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        if (absorb_byte(b, fin)) live_bytes++;
        if (typed) begin
            void'(awaited_items.pop_back());
            awaited_items.push_back(want);
        end
    endtask

    task automatic hold_until_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (awaited_items.size() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed frames; some noise, oversize lengths, bad checksums, truncation and trailing junk.
    task automatic send_frame();
        logic [7:0]  fb[$];
        logic [15:0] plen;
        logic [15:0] csum;
        int          pick;
        int          cut;
        bit          calm;
        pick = $urandom_range(0, 99);
        calm = ($urandom_range(0, 2) == 0);
        if (pick < 10) begin
            repeat ($urandom_range(1, 30)) fb.push_back(8'($urandom));
        end else begin
            repeat (8) fb.push_back(8'($urandom));
            pick = $urandom_range(0, 99);
            if (pick < 70) plen = 16'($urandom_range(0, 16));
            else if (pick < 82) plen = 16'($urandom_range(17, pfc_pkg::MAX_PAYLOAD - 1));
            else if (pick < 88) plen = 16'(pfc_pkg::MAX_PAYLOAD);
            else if (pick < 92) plen = 16'(pfc_pkg::MAX_PAYLOAD + 1);
            else if (pick < 95) plen = 16'hFFFF;
            else plen = 16'($urandom_range(pfc_pkg::MAX_PAYLOAD + 2, 16'hFFFE));
            fb.push_back(plen[15:8]);
            fb.push_back(plen[7:0]);
            if (plen > pfc_pkg::MAX_PAYLOAD) begin
                repeat ($urandom_range(0, 12)) fb.push_back(8'($urandom));
            end else begin
                repeat (plen) fb.push_back(8'($urandom));
                csum = ~frame_sum(fb);
                if ($urandom_range(0, 6) == 0) csum = 16'($urandom);
                fb.push_back(csum[15:8]);
                fb.push_back(csum[7:0]);
                if (plen == pfc_pkg::MAX_PAYLOAD)
                    repeat ($urandom_range(1, 4)) fb.push_back(8'($urandom));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                cut = $urandom_range(1, fb.size() - 1);
                while (fb.size() > cut) void'(fb.pop_back());
            end else if (pick == 1) begin
                repeat ($urandom_range(1, 6)) fb.push_back(8'($urandom));
            end
        end
        foreach (fb[i])
            send_byte(fb[i], i == fb.size() - 1, calm ? 0 : $urandom_range(0, 5), 1'b0, '0);
    endtask

    always @(posedge i_clk) begin
        if ((i_valid === 1'b1 && o_ready === 1'b1) || (o_valid === 1'b1 && i_ready === 1'b1))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("packet_frame_checker_top verification failed");
        $finish;
    end

    always @(posedge i_clk) begin
        pfc_pkg::t_item want;
        if (i_rst_n === 1'b1 && o_valid === 1'b1 && i_ready === 1'b1) begin
            if (awaited_items.size() == 0) begin
                $error("result transaction with nothing awaited");
                n_fail++;
            end else begin
                want = awaited_items.pop_front();
                check_field("item_kind", want.kind, o_item_kind);
                check_field("payload_byte", want.payload_byte, o_payload_byte);
                check_field("dst_station", want.dst_station, o_dst_station);
                check_field("src_station", want.src_station, o_src_station);
                check_field("packet_type", want.packet_type, o_packet_type);
                check_field("packet_ident", want.packet_ident, o_packet_ident);
                check_field("payload_length", want.payload_length, o_payload_length);
                check_field("received_checksum", want.received_checksum,
                            o_received_checksum);
                check_field("status", want.status, o_status);
            end
        end
    end

    // result side back-pressure
    initial begin
        int stall;
        int served;
        bit calm;
        served = 0;
        calm   = 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (served % 40 == 0) calm = ($urandom_range(0, 2) == 0);
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_valid === 1'b1 && i_ready === 1'b1));
            served++;
        end
    end

    initial begin
        int n_frames;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_data_byte  <= '0;
        i_final_byte <= 1'b0;
        i_ready      <= 1'b0;
        clear_frame();

        // one-byte frame
        row(8'hFF, 1'b1, 1'b1,
            closing(8'h00, 8'h00, 16'h0000, 32'h0000_00FF, 16'h0000, 16'h0000,
                    pfc_pkg::ST_UNDER));
        // maximum length field, no payload passed
        row(8'hFF);
        row(8'h00);
        row(8'hFF);
        row(8'hFF);
        row(8'h00);
        row(8'h00);
        row(8'h00);
        row(8'h00);
        row(8'hFF);
        row(8'hFF);
        row(8'h00);
        row(8'hFF, 1'b1, 1'b1,
            closing(8'hFF, 8'h00, 16'hFFFF, 32'h0000_0000, 16'hFFFF, 16'h0000,
                    pfc_pkg::ST_TOO_BIG));
        // stream ends on a payload byte, short for its length
        row(8'h00);
        row(8'hFF);
        row(8'h00);
        row(8'h00);
        row(8'hFF);
        row(8'hFF);
        row(8'hFF);
        row(8'hFF);
        row(8'h00);
        row(8'h03);
        row(8'h5A);
        row(8'hA5, 1'b1);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[k])
            send_byte(script[k].data, script[k].fin, $urandom_range(0, 5),
                      script[k].typed, script[k].want);
        hold_until_drained();

        n_frames = 0;
        while (live_bytes < RUN_ITEMS) begin
            send_frame();
            n_frames++;
            if (n_frames % 8 == 0) hold_until_drained();
        end
        hold_until_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (n_fail == 0)
            $display("packet_frame_checker_top verification clean");
        else
            $display("packet_frame_checker_top verification failed");
        $finish;
    end

endmodule
